@@ rtl/core/vpa_pkg.sv @@
package vpa_pkg;

    localparam int NUM_VOICES = 16;
    localparam int VOICE_W = $clog2(NUM_VOICES);
    localparam logic [VOICE_W-1:0] LAST_VOICE = VOICE_W'(NUM_VOICES - 1);

    localparam logic [4:0] NUM_CHIPS = 5'd4;
    localparam logic [1:0] DRUM_LANE = 2'd3;
    localparam logic [1:0] MUSIC_LANE_LIMIT = 2'd2;

    localparam logic [2:0] MODE_ALLOC = 3'd0;
    localparam logic [2:0] MODE_ASSIGN = 3'd1;
    localparam logic [2:0] MODE_FREE = 3'd2;
    localparam logic [2:0] MODE_STATUS = 3'd3;
    localparam logic [2:0] MODE_SWEEP = 3'd4;
    localparam logic [2:0] MODE_FIND_CH = 3'd5;
    localparam logic [2:0] MODE_FIND_PITCH = 3'd6;

    localparam logic [1:0] TYPE_MUSIC = 2'd0;
    localparam logic [1:0] TYPE_DRUM = 2'd1;

    typedef struct packed {
        logic        in_use;
        logic [3:0]  owner;
        logic [6:0]  note;
        logic [31:0] age;
        logic        osc_on;
        logic        osc_rel;
        logic [3:0]  osc_level;
    } voice_entry_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [3:0] voice;
        logic [3:0] channel;
        logic [6:0] pitch;
        logic [3:0] chip_mask;
        logic [4:0] limit;
        logic [1:0] vtype;
        logic       osc_active;
        logic       osc_releasing;
        logic [3:0] osc_volume;
        logic [3:0] start_voice;
    } req_t;

    typedef struct packed {
        logic               clear;
        logic               step;
        logic [VOICE_W-1:0] idx;
    } scan_ctl_t;

    typedef struct packed {
        logic               found;
        logic [VOICE_W-1:0] pick;
    } scan_res_t;

endpackage

@@ rtl/core/vpa_voice_ram.sv @@
module vpa_voice_ram (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [vpa_pkg::VOICE_W-1:0]   rd_addr,
    output vpa_pkg::voice_entry_t         rd_data,
    input  logic                          wr_en,
    input  logic [vpa_pkg::VOICE_W-1:0]   wr_addr,
    input  vpa_pkg::voice_entry_t         wr_data
);

    vpa_pkg::voice_entry_t mem [vpa_pkg::NUM_VOICES];
    vpa_pkg::voice_entry_t rd_data_reg;
    logic [vpa_pkg::NUM_VOICES-1:0] valid_reg;

    // An entry never written reads as the reset value of all zeros.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/vpa_scan.sv @@
module vpa_scan (
    input  logic                  clk,
    input  logic                  rst_n,
    input  vpa_pkg::scan_ctl_t    ctl,
    input  vpa_pkg::voice_entry_t entry,
    input  vpa_pkg::req_t         req,
    output vpa_pkg::scan_res_t    res
);

    logic [4:0]                  active_reg, active_next;
    logic [vpa_pkg::VOICE_W-1:0] free_v_reg, free_v_next;
    logic                        have_free_reg, have_free_next;
    logic [vpa_pkg::VOICE_W-1:0] steal_v_reg, steal_v_next;
    logic                        have_steal_reg, have_steal_next;
    logic                        took_rel_reg, took_rel_next;
    logic [3:0]                  low_vol_reg, low_vol_next;
    logic [31:0]                 low_age_reg, low_age_next;
    logic [vpa_pkg::VOICE_W-1:0] find_v_reg, find_v_next;
    logic                        have_find_reg, have_find_next;

    logic [6:0] idx7;
    logic [4:0] chip;
    logic [1:0] lane;
    logic       chip_ok;
    logic       lane_ok;
    logic       owned;
    logic       better;

    assign idx7 = 7'(ctl.idx);
    assign chip = idx7[6:2];
    assign lane = idx7[1:0];
    assign chip_ok = (chip < vpa_pkg::NUM_CHIPS) && req.chip_mask[chip[1:0]];
    assign owned = entry.in_use && (entry.owner == req.channel);

    always_comb
    begin
        unique case (req.vtype)
            vpa_pkg::TYPE_MUSIC: lane_ok = chip_ok && (lane < vpa_pkg::MUSIC_LANE_LIMIT);
            vpa_pkg::TYPE_DRUM:  lane_ok = chip_ok && (lane == vpa_pkg::DRUM_LANE);
            default:             lane_ok = chip_ok;
        endcase
    end

    // A releasing voice wins until one is held; after that only releasing voices compete.
    assign better = ((!took_rel_reg && entry.osc_rel) || !have_steal_reg
                     || (entry.osc_level < low_vol_reg)
                     || ((entry.osc_level == low_vol_reg) && (entry.age < low_age_reg)))
                    && !(took_rel_reg && !entry.osc_rel);

    always_comb
    begin
        active_next = active_reg;
        free_v_next = free_v_reg;
        have_free_next = have_free_reg;
        steal_v_next = steal_v_reg;
        have_steal_next = have_steal_reg;
        took_rel_next = took_rel_reg;
        low_vol_next = low_vol_reg;
        low_age_next = low_age_reg;
        find_v_next = find_v_reg;
        have_find_next = have_find_reg;
        if (ctl.clear)
        begin
            active_next = '0;
            have_free_next = 1'b0;
            free_v_next = '0;
            have_steal_next = 1'b0;
            steal_v_next = '0;
            took_rel_next = 1'b0;
            low_vol_next = '0;
            low_age_next = '0;
            have_find_next = 1'b0;
            find_v_next = '0;
        end
        else if (ctl.step)
        begin
            if ((req.mode == vpa_pkg::MODE_ALLOC) && (active_reg < req.limit) && lane_ok)
            begin
                if (!entry.in_use || !entry.osc_on)
                begin
                    free_v_next = ctl.idx;
                    have_free_next = 1'b1;
                end
                else if (entry.owner == req.channel)
                begin
                    active_next = active_reg + 5'd1;
                    if (better)
                    begin
                        took_rel_next = took_rel_reg || entry.osc_rel;
                        low_vol_next = entry.osc_level;
                        low_age_next = entry.age;
                        steal_v_next = ctl.idx;
                        have_steal_next = 1'b1;
                    end
                end
            end
            if (!have_find_reg && owned
                && (((req.mode == vpa_pkg::MODE_FIND_CH))
                    || ((req.mode == vpa_pkg::MODE_FIND_PITCH)
                        && (entry.note == req.pitch)
                        && (7'(req.start_voice) <= idx7))))
            begin
                find_v_next = ctl.idx;
                have_find_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            have_free_reg <= 1'b0;
            have_steal_reg <= 1'b0;
            took_rel_reg <= 1'b0;
            have_find_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            have_free_reg <= have_free_next;
            have_steal_reg <= have_steal_next;
            took_rel_reg <= took_rel_next;
            have_find_reg <= have_find_next;
        end
    end

    always_ff @(posedge clk)
    begin
        free_v_reg <= free_v_next;
        steal_v_reg <= steal_v_next;
        low_vol_reg <= low_vol_next;
        low_age_reg <= low_age_next;
        find_v_reg <= find_v_next;
    end

    always_comb
    begin
        res = '0;
        if (req.mode == vpa_pkg::MODE_ALLOC)
        begin
            if ((active_reg < req.limit) && have_free_reg)
            begin
                res.found = 1'b1;
                res.pick = free_v_reg;
            end
            else if (have_steal_reg)
            begin
                res.found = 1'b1;
                res.pick = steal_v_reg;
            end
        end
        else if (have_find_reg)
        begin
            res.found = 1'b1;
            res.pick = find_v_reg;
        end
    end

endmodule

@@ rtl/core/polyphonic_voice_allocator_top.sv @@
// Channel | Handshake             | Payload
// input   | in_valid / in_ready   | mode, voice, channel, pitch, chip_mask, max_per_channel,
//         |                       | voice_type, osc_active, osc_releasing, osc_volume, start_voice
// output  | out_valid / out_ready | voice_index, found
//
// Allocate, sweep and both lookups walk the voice RAM one entry per cycle; assign, free
// and status read and write back only the addressed voice.
// The single read port of the voice RAM sets this pace.
// Reset clears the valid bits of the RAM, so every voice reads as zero until written.
// A result waits in the output register; a new item is taken while it waits, and the
// block stalls at the end of that item until the old result has been transferred.
module polyphonic_voice_allocator_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] mode,
    input  logic [3:0] voice,
    input  logic [3:0] channel,
    input  logic [6:0] pitch,
    input  logic [3:0] chip_mask,
    input  logic [4:0] max_per_channel,
    input  logic [1:0] voice_type,
    input  logic       osc_active,
    input  logic       osc_releasing,
    input  logic [3:0] osc_volume,
    input  logic [3:0] start_voice,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] voice_index,
    output logic       found
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_RUN    = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;
    vpa_pkg::req_t req_reg, req_next;
    logic [vpa_pkg::VOICE_W-1:0] rd_addr_reg, rd_addr_next;
    logic issuing_reg, issuing_next;
    logic rd_pend_reg;
    logic rd_last_reg;
    logic [vpa_pkg::VOICE_W-1:0] rd_idx_reg;
    logic [31:0] age_counter_reg, age_counter_next;
    logic out_valid_reg, out_valid_next;
    logic [3:0] voice_index_reg, voice_index_next;
    logic found_reg, found_next;

    logic in_xfer;
    logic is_rmw;
    logic in_is_rmw;
    logic in_voice_ok;
    logic req_voice_ok;
    logic rd_en;
    logic issue_last;
    logic wr_en;
    vpa_pkg::voice_entry_t rd_data;
    vpa_pkg::voice_entry_t wr_data;
    vpa_pkg::scan_ctl_t scan_ctl;
    vpa_pkg::scan_res_t scan_res;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer = in_valid && in_ready;
    assign in_is_rmw = (mode == vpa_pkg::MODE_ASSIGN) || (mode == vpa_pkg::MODE_FREE)
                       || (mode == vpa_pkg::MODE_STATUS);
    assign is_rmw = (req_reg.mode == vpa_pkg::MODE_ASSIGN)
                    || (req_reg.mode == vpa_pkg::MODE_FREE)
                    || (req_reg.mode == vpa_pkg::MODE_STATUS);
    assign in_voice_ok = 7'(voice) < 7'(vpa_pkg::NUM_VOICES);
    assign req_voice_ok = 7'(req_reg.voice) < 7'(vpa_pkg::NUM_VOICES);

    assign rd_en = (state_reg == ST_RUN) && issuing_reg;
    assign issue_last = is_rmw || (rd_addr_reg == vpa_pkg::LAST_VOICE);

    assign scan_ctl.clear = in_xfer;
    assign scan_ctl.step = rd_pend_reg;
    assign scan_ctl.idx = rd_idx_reg;

    vpa_voice_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (rd_idx_reg),
        .wr_data (wr_data)
    );

    vpa_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (scan_ctl),
        .entry (rd_data),
        .req   (req_reg),
        .res   (scan_res)
    );

    // Write-back of the entry whose read data arrives this cycle.
    always_comb
    begin
        wr_en = 1'b0;
        wr_data = rd_data;
        age_counter_next = age_counter_reg;
        if (rd_pend_reg)
        begin
            unique case (req_reg.mode)
                vpa_pkg::MODE_ASSIGN:
                begin
                    wr_en = 1'b1;
                    wr_data.in_use = 1'b1;
                    wr_data.owner = req_reg.channel;
                    wr_data.note = req_reg.pitch;
                    wr_data.age = age_counter_reg;
                    age_counter_next = age_counter_reg + 32'd1;
                end
                vpa_pkg::MODE_FREE:
                begin
                    wr_en = 1'b1;
                    wr_data.in_use = 1'b0;
                    wr_data.owner = '0;
                    wr_data.note = '0;
                    wr_data.age = '0;
                end
                vpa_pkg::MODE_STATUS:
                begin
                    wr_en = 1'b1;
                    wr_data.osc_on = req_reg.osc_active;
                    wr_data.osc_rel = req_reg.osc_releasing;
                    wr_data.osc_level = req_reg.osc_volume;
                end
                vpa_pkg::MODE_SWEEP:
                begin
                    wr_en = rd_data.in_use && !rd_data.osc_on;
                    wr_data.in_use = 1'b0;
                    wr_data.owner = '0;
                    wr_data.note = '0;
                    wr_data.age = '0;
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_next = req_reg;
        rd_addr_next = rd_addr_reg;
        issuing_next = issuing_reg;
        out_valid_next = out_valid_reg && !out_ready;
        voice_index_next = voice_index_reg;
        found_next = found_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    req_next.mode = mode;
                    req_next.voice = voice;
                    req_next.channel = channel;
                    req_next.pitch = pitch;
                    req_next.chip_mask = chip_mask;
                    req_next.limit = max_per_channel;
                    req_next.vtype = voice_type;
                    req_next.osc_active = osc_active;
                    req_next.osc_releasing = osc_releasing;
                    req_next.osc_volume = osc_volume;
                    req_next.start_voice = start_voice;
                    if (in_is_rmw)
                    begin
                        rd_addr_next = vpa_pkg::VOICE_W'(voice);
                        issuing_next = in_voice_ok;
                        state_next = in_voice_ok ? ST_RUN : ST_FINISH;
                    end
                    else if (mode == vpa_pkg::MODE_ALLOC || mode == vpa_pkg::MODE_SWEEP
                             || mode == vpa_pkg::MODE_FIND_CH
                             || mode == vpa_pkg::MODE_FIND_PITCH)
                    begin
                        rd_addr_next = '0;
                        issuing_next = 1'b1;
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        issuing_next = 1'b0;
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_RUN:
            begin
                if (issuing_reg)
                begin
                    rd_addr_next = rd_addr_reg + vpa_pkg::VOICE_W'(1);
                    issuing_next = !issue_last;
                end
                if (rd_pend_reg && rd_last_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    voice_index_next = '0;
                    found_next = 1'b0;
                    if (is_rmw)
                    begin
                        if (req_voice_ok)
                        begin
                            voice_index_next = req_reg.voice;
                            found_next = 1'b1;
                        end
                    end
                    else if (req_reg.mode == vpa_pkg::MODE_ALLOC
                             || req_reg.mode == vpa_pkg::MODE_FIND_CH
                             || req_reg.mode == vpa_pkg::MODE_FIND_PITCH)
                    begin
                        voice_index_next = 4'(scan_res.pick);
                        found_next = scan_res.found;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            issuing_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            rd_last_reg <= 1'b0;
            age_counter_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            issuing_reg <= issuing_next;
            rd_pend_reg <= rd_en;
            rd_last_reg <= rd_en && issue_last;
            age_counter_reg <= age_counter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rd_addr_reg <= rd_addr_next;
        rd_idx_reg <= rd_addr_reg;
        voice_index_reg <= voice_index_next;
        found_reg <= found_next;
    end

    assign out_valid = out_valid_reg;
    assign voice_index = voice_index_reg;
    assign found = found_reg;

endmodule
